### hdl/ieu_pkg.sv
`default_nettype none
package ieu_pkg;
    localparam int unsigned W = 32;
    localparam int unsigned DivStages = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_LT = 4'd4, OP_LE = 4'd5, OP_EQ = 4'd6, OP_GE = 4'd7,
        OP_GT = 4'd8, OP_NE = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_DIV_OVERFLOW = 2'd2
    } t_err;

    localparam logic [W-1:0] IntMin = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] value;
        logic [1:0]   err;
        logic         is_div;
        logic         neg_q;
    } t_side;
endpackage
`default_nettype wire

### hdl/ieu_divider.sv
`default_nettype none
module ieu_divider (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [ieu_pkg::W-1:0] i_num,
    input  wire logic [ieu_pkg::W-1:0] i_den,
    input  wire ieu_pkg::t_side       i_side,
    output logic                      o_valid,
    output logic [ieu_pkg::W-1:0]     o_quo,
    output logic                      o_rem_nz,
    output ieu_pkg::t_side            o_side
);
    import ieu_pkg::*;

    logic [W-1:0] r_q   [DivStages+1];
    logic [W-1:0] r_rem [DivStages+1];
    logic [W-1:0] r_den [DivStages+1];
    t_side        r_sd  [DivStages+1];
    logic         r_v   [DivStages+1];

    assign r_q[0] = i_num;
    assign r_rem[0] = '0;
    assign r_den[0] = i_den;
    assign r_sd[0] = i_side;
    assign r_v[0] = i_valid;

    for (genvar s = 0; s < DivStages; s++) begin : g_st
        logic [W:0]   n_trial;
        logic [W-1:0] n_shift;
        logic         n_fit;
        assign n_shift = {r_rem[s][W-2:0], r_q[s][W-1]};
        assign n_trial = {r_rem[s][W-1], n_shift} - {1'b0, r_den[s]};
        assign n_fit = !n_trial[W];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_fit ? n_trial[W-1:0] : n_shift;
                r_q[s+1] <= {r_q[s][W-2:0], n_fit};
                r_den[s+1] <= r_den[s];
                r_sd[s+1] <= r_sd[s];
            end
        end
    end

    assign o_valid = r_v[DivStages];
    assign o_quo = r_q[DivStages];
    assign o_rem_nz = |r_rem[DivStages];
    assign o_side = r_sd[DivStages];
endmodule
`default_nettype wire

### hdl/ir_integer_execute_unit.sv
`default_nettype none
// Channel | Dir | tdata fields (low bit up)               | tuser
// s_axis  | in  | mode[3:0], lhs_value[35:4], rhs[67:36]  | -
// m_axis  | out | result_value[31:0], error_code[33:32]   | -
// A result passes through one decode stage, 32 restoring divider stages, and one fixup
// stage before it is offered; one item enters per cycle while m_axis is not stalled.
// Reset (synchronous, active low) clears all valid bits.
// A stall on m_axis freezes the whole pipeline; an empty output slot lets it move.
module ir_integer_execute_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // mode, lhs_value, rhs_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // result_value, error_code
);
    import ieu_pkg::*;

    logic         en;
    logic [3:0]   mode;
    logic [W-1:0] a, b, ma, mb, prod;
    logic         r_v1;
    logic [W-1:0] r_num, r_den;
    t_side        r_sd, n_sd;
    logic         dv;
    logic [W-1:0] dq, q;
    logic         drnz;
    t_side        dsd;
    logic         r_ov;
    logic [W-1:0] r_res;
    logic [1:0]   r_err;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign mode = s_axis_tdata[3:0];
    assign a = s_axis_tdata[35:4];
    assign b = s_axis_tdata[67:36];
    assign ma = a[W-1] ? -a : a;
    assign mb = b[W-1] ? -b : b;
    assign prod = a * b;

    always_comb begin
        n_sd = '0;
        unique case (mode)
            OP_ADD: n_sd.value = a + b;
            OP_SUB: n_sd.value = a - b;
            OP_MUL: n_sd.value = prod;
            OP_DIV: begin
                if (b == '0) begin
                    n_sd.err = ERR_DIV_ZERO;
                end else if (a == IntMin && b == '1) begin
                    n_sd.err = ERR_DIV_OVERFLOW;
                end else begin
                    n_sd.is_div = 1'b1;
                    n_sd.neg_q = a[W-1] ^ b[W-1];
                end
            end
            OP_LT: n_sd.value = {{(W-1){1'b0}}, $signed(a) < $signed(b)};
            OP_LE: n_sd.value = {{(W-1){1'b0}}, $signed(a) <= $signed(b)};
            OP_EQ: n_sd.value = {{(W-1){1'b0}}, a == b};
            OP_GE: n_sd.value = {{(W-1){1'b0}}, $signed(a) >= $signed(b)};
            OP_GT: n_sd.value = {{(W-1){1'b0}}, $signed(a) > $signed(b)};
            OP_NE: n_sd.value = {{(W-1){1'b0}}, a != b};
            default: n_sd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_ov <= dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= ma;
            r_den <= mb;
            r_sd <= n_sd;
            r_res <= dsd.is_div ? q : dsd.value;
            r_err <= dsd.err;
        end
    end

    ieu_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_num(r_num), .i_den(r_den), .i_side(r_sd),
        .o_valid(dv), .o_quo(dq), .o_rem_nz(drnz), .o_side(dsd)
    );

    assign q = dsd.neg_q ? (drnz ? ~dq : -dq) : dq;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {6'd0, r_err, r_res};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] != ERR_NONE |-> m_axis_tdata[31:0] == '0)
        else $error("error without zero result");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
        else $error("bad error code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
endmodule
`default_nettype wire
